@@ hdl/sha1_byte_stream_hasher_core_assert.svh @@
// Assertion macros for the SHA-1 byte stream hasher.
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define S1BH_ASSERT_COMB(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define S1BH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/s1bh_pkg.sv @@
// Shared types, constants and round functions of the SHA-1 hasher.
`timescale 1ns / 1ps

package s1bh_pkg;

  localparam int SCHED_DEPTH = 16;

  typedef logic [31:0]      word_t;
  typedef logic [3:0]       sidx_t;
  typedef logic [6:0]       rnd_t;
  typedef logic [4:0][31:0] chain_t;

  localparam chain_t CHAIN_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                 32'hefcdab89, 32'h67452301};

  localparam word_t K_R0 = 32'h5a827999;
  localparam word_t K_R1 = 32'h6ed9eba1;
  localparam word_t K_R2 = 32'h8f1bbcdc;
  localparam word_t K_R3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam rnd_t SCHED_ROUNDS = 7'd16;
  localparam rnd_t LAST_ROUND   = 7'd79;
  localparam rnd_t GROUP1_START = 7'd20;
  localparam rnd_t GROUP2_START = 7'd40;
  localparam rnd_t GROUP3_START = 7'd60;

  localparam sidx_t LEN_HI_IDX = 4'd14;
  localparam sidx_t LEN_LO_IDX = 4'd15;

  localparam logic [2:0] WORD_LAST = 3'd4;

  // Sequencer commands to the round datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic init;
  } rnd_ctl_t;

  typedef struct packed {
    logic  we;
    sidx_t addr;
    word_t data;
  } sched_wr_t;

  typedef struct packed {
    sidx_t a0;
    sidx_t a1;
    sidx_t b0;
    sidx_t b1;
  } sched_rd_t;

  typedef struct packed {
    word_t a0;
    word_t a1;
    word_t b0;
    word_t b1;
  } sched_q_t;

  function automatic word_t round_f(rnd_t r, word_t b, word_t c, word_t d);
    word_t f;
    if (r < GROUP1_START) begin
      f = d ^ (b & (c ^ d));
    end else if (r < GROUP2_START) begin
      f = b ^ c ^ d;
    end else if (r < GROUP3_START) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(rnd_t r);
    word_t k;
    if (r < GROUP1_START) begin
      k = K_R0;
    end else if (r < GROUP2_START) begin
      k = K_R1;
    end else if (r < GROUP3_START) begin
      k = K_R2;
    end else begin
      k = K_R3;
    end
    return k;
  endfunction

endpackage

@@ hdl/sha1_byte_stream_hasher_core.sv @@
// Top level of the SHA-1 byte stream hasher: sequencer, byte packing and digest output.
`timescale 1ns / 1ps

// Takes one message byte per input transfer and returns the 160-bit SHA-1 digest as five
// 32-bit output transfers, H0 first, after a transfer with end_of_message set. The 64th
// byte of a block holds off input while the compression runs: a load step, 80 rounds at
// one round per cycle with the message schedule read from and expanded in place in the
// schedule memory, and a fold of the result into the chaining words. At the end of a
// message the block writes the remaining padding words, one per cycle, compresses,
// repeats both with 16 writes when 8 or fewer bytes were free, then moves the five digest
// words out one per cycle as the output side takes them. A new message can start as soon
// as the last digest word sits in the output register.
module sha1_byte_stream_hasher_core import s1bh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

`include "sha1_byte_stream_hasher_core_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_PRIME = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_FOLD  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  rnd_t        rnd_r, rnd_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bit_cnt_r, bit_cnt_nxt;
  sidx_t       pad_idx_r, pad_idx_nxt;
  logic        mark_r, mark_nxt;
  logic        final_r, final_nxt;
  logic        pad_mode_r, pad_mode_nxt;
  logic        eom_pend_r, eom_pend_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  word_t       asm_r, asm_nxt;
  word_t       out_word_r, out_word_nxt;
  logic [2:0]  out_index_r, out_index_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_acc;
  logic [5:0]  end_pos;
  word_t       asm_byte;
  word_t       marker_word;
  word_t       w_exp;
  word_t       w_cur;
  sidx_t       rd_base;
  sched_wr_t   sched_wr;
  sched_rd_t   sched_ra;
  sched_q_t    sched_q;
  rnd_ctl_t    rnd_ctl;
  chain_t      chain;

  s1bh_sched_mem u_sched (
    .clk (clk),
    .wr  (sched_wr),
    .ra  (sched_ra),
    .rq  (sched_q)
  );

  s1bh_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rnd_ctl),
    .rnd   (rnd_r),
    .w     (w_cur),
    .chain (chain)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign end_pos  = in_has_byte ? (pos_r + 6'd1) : pos_r;

  always_comb begin
    case (pos_r[1:0])
      2'd0:    asm_byte = {in_msg_byte, 24'h0};
      2'd1:    asm_byte = {asm_r[31:24], in_msg_byte, 16'h0};
      2'd2:    asm_byte = {asm_r[31:16], in_msg_byte, 8'h0};
      default: asm_byte = {asm_r[31:8], in_msg_byte};
    endcase
  end

  always_comb begin
    case (pos_r[1:0])
      2'd0:    marker_word = {PAD_MARKER, 24'h0};
      2'd1:    marker_word = {asm_r[31:24], PAD_MARKER, 16'h0};
      2'd2:    marker_word = {asm_r[31:16], PAD_MARKER, 8'h0};
      default: marker_word = {asm_r[31:8], PAD_MARKER};
    endcase
  end

  // Issue the taps for the next round in the cycle before it; the round's own write never
  // lands on any of them.
  assign rd_base     = (state_r == ST_ROUND) ? (rnd_r[3:0] + 4'd1) : 4'd0;
  assign sched_ra.a0 = rd_base + 4'd13;
  assign sched_ra.a1 = rd_base + 4'd8;
  assign sched_ra.b0 = rd_base + 4'd2;
  assign sched_ra.b1 = rd_base;

  assign w_exp = {sched_q.a0[30:0] ^ sched_q.a1[30:0] ^ sched_q.b0[30:0] ^ sched_q.b1[30:0],
                  sched_q.a0[31] ^ sched_q.a1[31] ^ sched_q.b0[31] ^ sched_q.b1[31]};
  assign w_cur = (rnd_r < SCHED_ROUNDS) ? sched_q.b1 : w_exp;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    bit_cnt_nxt   = bit_cnt_r;
    pad_idx_nxt   = pad_idx_r;
    mark_nxt      = mark_r;
    final_nxt     = final_r;
    pad_mode_nxt  = pad_mode_r;
    eom_pend_nxt  = eom_pend_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    asm_nxt       = asm_r;
    out_word_nxt  = out_word_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;
    sched_wr      = '0;
    rnd_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            asm_nxt     = asm_byte;
            bit_cnt_nxt = bit_cnt_r + 64'd8;
            pos_nxt     = pos_r + 6'd1;
            if (pos_r[1:0] == 2'd3) begin
              sched_wr.we   = 1'b1;
              sched_wr.addr = pos_r[5:2];
              sched_wr.data = asm_byte;
            end
          end
          if (in_has_byte && (pos_r == 6'd63)) begin
            eom_pend_nxt = in_end_of_message;
            state_nxt    = ST_PRIME;
          end else if (in_end_of_message) begin
            pad_idx_nxt  = end_pos[5:2];
            mark_nxt     = 1'b1;
            final_nxt    = (end_pos[5:2] < LEN_HI_IDX);
            pad_mode_nxt = 1'b1;
            state_nxt    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_wr.we   = 1'b1;
        sched_wr.addr = pad_idx_r;
        if (mark_r) begin
          sched_wr.data = marker_word;
        end else if (final_r && (pad_idx_r == LEN_HI_IDX)) begin
          sched_wr.data = bit_cnt_r[63:32];
        end else if (final_r && (pad_idx_r == LEN_LO_IDX)) begin
          sched_wr.data = bit_cnt_r[31:0];
        end else begin
          sched_wr.data = '0;
        end
        mark_nxt    = 1'b0;
        pad_idx_nxt = pad_idx_r + 4'd1;
        if (pad_idx_r == LEN_LO_IDX) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        rnd_ctl.load = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_ctl.step = 1'b1;
        if (rnd_r >= SCHED_ROUNDS) begin
          sched_wr.we   = 1'b1;
          sched_wr.addr = rnd_r[3:0];
          sched_wr.data = w_exp;
        end
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        rnd_ctl.fold = 1'b1;
        rnd_nxt      = '0;
        if (pad_mode_r) begin
          if (final_r) begin
            out_idx_nxt = '0;
            state_nxt   = ST_OUT;
          end else begin
            // length goes into a second, otherwise empty block
            final_nxt   = 1'b1;
            pad_idx_nxt = '0;
            state_nxt   = ST_PAD;
          end
        end else if (eom_pend_r) begin
          eom_pend_nxt = 1'b0;
          pad_mode_nxt = 1'b1;
          mark_nxt     = 1'b1;
          final_nxt    = 1'b1;
          pad_idx_nxt  = '0;
          state_nxt    = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain[out_idx_r];
          out_index_nxt = out_idx_r;
          out_last_nxt  = (out_idx_r == WORD_LAST);
          out_idx_nxt   = out_idx_r + 3'd1;
          if (out_idx_r == WORD_LAST) begin
            // restart from the initial chain for the next message
            rnd_ctl.init = 1'b1;
            bit_cnt_nxt  = '0;
            pos_nxt      = '0;
            pad_mode_nxt = 1'b0;
            final_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      pos_r       <= '0;
      bit_cnt_r   <= '0;
      pad_idx_r   <= '0;
      mark_r      <= 1'b0;
      final_r     <= 1'b0;
      pad_mode_r  <= 1'b0;
      eom_pend_r  <= 1'b0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pad_idx_r   <= pad_idx_nxt;
      mark_r      <= mark_nxt;
      final_r     <= final_nxt;
      pad_mode_r  <= pad_mode_nxt;
      eom_pend_r  <= eom_pend_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r       <= asm_nxt;
    out_word_r  <= out_word_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  `S1BH_ASSERT_COMB(a_round_range, clk, rst_n, state_r == ST_ROUND,
                    rnd_r <= LAST_ROUND, "round index past last round")
  `S1BH_ASSERT_COMB(a_no_tap_clash, clk, rst_n, (state_r == ST_ROUND) && sched_wr.we,
                    (sched_wr.addr != sched_ra.a0) && (sched_wr.addr != sched_ra.a1) &&
                    (sched_wr.addr != sched_ra.b0) && (sched_wr.addr != sched_ra.b1),
                    "schedule write hits a tap read in the same cycle")
  `S1BH_ASSERT_NEXT(a_prime_to_round, clk, rst_n, state_r == ST_PRIME,
                    (state_r == ST_ROUND) && (rnd_r == '0),
                    "compression did not start at round zero")
  `S1BH_ASSERT_COMB(a_out_from_out_state, clk, rst_n, $rose(out_valid_r),
                    $past(state_r) == ST_OUT, "digest word loaded outside output state")

endmodule

@@ hdl/s1bh_sched_mem.sv @@
// Message schedule store: two mirrored 16-word memories, four registered reads a cycle.
`timescale 1ns / 1ps

module s1bh_sched_mem import s1bh_pkg::*; (
  input  logic      clk,
  input  sched_wr_t wr,
  input  sched_rd_t ra,
  output sched_q_t  rq
);

  word_t    mem_a_r [SCHED_DEPTH];
  word_t    mem_b_r [SCHED_DEPTH];
  sched_q_t rq_r;

  // Both copies take every write; each serves two of the four taps.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_a_r[wr.addr] <= wr.data;
      mem_b_r[wr.addr] <= wr.data;
    end
    rq_r.a0 <= mem_a_r[ra.a0];
    rq_r.a1 <= mem_a_r[ra.a1];
    rq_r.b0 <= mem_b_r[ra.b0];
    rq_r.b1 <= mem_b_r[ra.b1];
  end

  assign rq = rq_r;

endmodule

@@ hdl/s1bh_round.sv @@
// Round datapath: working variables, one SHA-1 round per step, and chaining words.
`timescale 1ns / 1ps

module s1bh_round import s1bh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rnd_ctl_t ctl,
  input  rnd_t     rnd,
  input  word_t    w,
  output chain_t   chain
);

  word_t  a_r, b_r, c_r, d_r, e_r;
  chain_t chain_r;
  chain_t work;
  word_t  t;

  assign t = {a_r[26:0], a_r[31:27]} + e_r + w + round_f(rnd, b_r, c_r, d_r) + round_k(rnd);
  assign work = {e_r, d_r, c_r, b_r, a_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctl.step) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= CHAIN_IV;
    end else if (ctl.init) begin
      chain_r <= CHAIN_IV;
    end else if (ctl.fold) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_r[i] + work[i];
      end
    end
  end

  assign chain = chain_r;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the SHA-1 byte stream hasher core.
`timescale 1ns / 1ps

module testbench;
  import s1bh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_HOLD      = 300;
  localparam int ITEM_TARGET    = 500;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_msg_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Predictor state: chaining words, schedule block, length and block position.
  logic [31:0] chain_h [5];
  logic [31:0] sched_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;

  digest_exp_t digest_q [$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  bit          idle_on     = 1'b0;
  int          hold_off_len = 0;

  sha1_byte_stream_hasher_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_msg_byte       (in_msg_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 5; i++) chain_h[i] = CHAIN_IV[i];
    msg_bits = 64'd0;
    blk_pos  = 6'd0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t, wr;
    w = sched_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rol32(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d));
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rol32(a, 5) + e + wr + f + k;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Pack big-endian; the first byte of a word overwrites it.
  function automatic void put_sched_byte(logic [5:0] pos, logic [7:0] b);
    logic [31:0] v;
    int sh;
    sh = 24 - 8 * int'(pos[1:0]);
    v = {24'd0, b} << sh;
    if (pos[1:0] == 2'd0) sched_w[pos[5:2]] = v;
    else sched_w[pos[5:2]] |= v;
  endfunction

  function automatic void sha1_absorb(logic [7:0] b, logic hb, logic eom);
    digest_exp_t d;
    int p;
    if (hb) begin
      put_sched_byte(blk_pos, b);
      msg_bits += 64'd8;
      blk_pos  += 6'd1;
      if (blk_pos == 6'd0) sha1_compress();
    end
    if (eom) begin
      p = int'(blk_pos);
      put_sched_byte(6'(p), PAD_MARKER);
      for (int i = p + 1; i < 64; i++) put_sched_byte(6'(i), 8'h00);
      // no room for the length: flush and pad a fresh block
      if (p >= 56) begin
        sha1_compress();
        for (int i = 0; i < 16; i++) sched_w[i] = 32'd0;
      end
      sched_w[LEN_HI_IDX] = msg_bits[63:32];
      sched_w[LEN_LO_IDX] = msg_bits[31:0];
      sha1_compress();
      for (int i = 0; i < 5; i++) begin
        d.word  = chain_h[i];
        d.index = 3'(i);
        d.last  = (3'(i) == WORD_LAST);
        digest_q.push_back(d);
      end
      restart_chain();
    end
  endfunction

  // Offer one item from the falling edge and hold it until the transfer.
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_msg_byte       <= b;
    in_has_byte       <= hb;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sha1_absorb(b, hb, eom);
    if (hb || eom) items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_digests();
    release_input();
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_msg_len();
    int edges [8] = '{55, 56, 57, 62, 63, 64, 119, 120};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom_range(0, 8);
    if (sel < 8) return edges[$urandom_range(0, 7)];
    return $urandom_range(0, 130);
  endfunction

  task automatic send_message(input int len);
    bit tail_eom;
    tail_eom = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      // sprinkle items that carry neither a byte nor an end marker
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, tail_eom && (i == len - 1));
    end
    if (!tail_eom) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed_cases();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    wait_digests();
  endtask

  task automatic test_output_backpressure();
    hold_off_len = LONG_HOLD;
    for (int m = 0; m < 4; m++) send_message($urandom_range(1, 6));
    wait_digests();
  endtask

  task automatic test_pause_for_digest();
    for (int m = 0; m < 3; m++) begin
      send_message(pick_msg_len());
      wait_digests();
    end
  endtask

  task automatic test_random_messages();
    while (items_sent < ITEM_TARGET - 80) send_message(pick_msg_len());
  endtask

  task automatic test_full_rate_tail();
    while (items_sent < ITEM_TARGET) send_message($urandom_range(0, 70));
    wait_digests();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    digest_exp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest transfer: word %h index %0d", out_digest_word,
               out_word_index);
        mismatches++;
      end else begin
        e = digest_q.pop_front();
        if (out_digest_word !== e.word) begin
          $error("digest_word: expected %h, got %h", e.word, out_digest_word);
          mismatches++;
        end
        if (out_word_index !== e.index) begin
          $error("word_index: expected %0d, got %0d", e.index, out_word_index);
          mismatches++;
        end
        if (out_last_word !== e.last) begin
          $error("last_word: expected %0d, got %0d", e.last, out_last_word);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_msg_byte       = 8'd0;
    in_has_byte       = 1'b0;
    in_end_of_message = 1'b0;
    restart_chain();
    for (int i = 0; i < 16; i++) sched_w[i] = 32'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    idle_on = 1'b1;
    test_output_backpressure();
    test_pause_for_digest();
    test_random_messages();
    idle_on = 1'b0;
    test_full_rate_tail();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
